FILE: sv/hsr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsr_pkg: shared types and constants for the Heron square root block
// Field widths, register indexes, controller state codes and the command and
// status groups that join the controller to the datapath.
// ----------------------------------------------------------------------------
package hsr_pkg;

   localparam int RADICAND_W = 32;
   localparam int ROOT_W     = 24;
   localparam int ROUNDS_W   = 7;
   localparam int TOL_W      = 16;
   localparam int LIMIT_W    = 7;
   localparam int WORK_W     = 32;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_TOLERANCE_LSBS  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ITERATION_LIMIT = 1'b1;

   localparam logic [TOL_W-1:0]   TOLERANCE_RESET = 16'd1;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET     = 7'd32;

   localparam logic [ROOT_W-1:0] ROOT_SAT = {ROOT_W{1'b1}};

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_CHECK  = 4'b0010,
      ST_DIVIDE = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   typedef struct packed {
      logic load;         // take a new radicand
      logic start_round;  // average x and y, arm the divider
      logic div_step;     // one quotient bit
      logic capture;      // load the result register
   } cmd_type;

   typedef struct packed {
      logic not_positive; // radicand is zero or negative
      logic within_tol;   // |x - y| within tolerance
      logic limit_hit;    // round limit reached
      logic div_last;     // divider on its final bit
   } status_type;

endpackage

FILE: sv/hsr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsr_ctrl: sequencer for the Heron square root block
// Steps each word through tolerance checks and divider rounds, and owns the
// handshake flags of both channels.
// ----------------------------------------------------------------------------
module hsr_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   input  hsr_pkg::status_type status,
   output hsr_pkg::cmd_type    cmd
);

   hsr_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic slot_free;

   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         hsr_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = hsr_pkg::ST_CHECK;
            end
         end
         hsr_pkg::ST_CHECK: begin
            if (status.not_positive || status.within_tol || status.limit_hit) begin
               state_in = hsr_pkg::ST_FINISH;
            end else begin
               cmd.start_round = 1'b1;
               state_in        = hsr_pkg::ST_DIVIDE;
            end
         end
         hsr_pkg::ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = hsr_pkg::ST_CHECK;
            end
         end
         hsr_pkg::ST_FINISH: begin
            // wait for the result register to free up
            if (slot_free) begin
               cmd.capture = 1'b1;
               state_in    = hsr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = hsr_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      priority if (cmd.capture) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hsr_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != hsr_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: sv/hsr_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsr_datapath: estimate, quotient and divider of the Heron square root block
// Holds the settings, the x/y pair, the round count, a restoring divider that
// makes one quotient bit per cycle, and the result register.
// ----------------------------------------------------------------------------
module hsr_datapath #(
   parameter int FRACTION_BITS = 16,
   parameter int MAX_ROUNDS    = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [hsr_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [hsr_pkg::CSR_DATA_W-1:0]       csr_write_data,
   input  logic signed [hsr_pkg::RADICAND_W-1:0] req_radicand,
   input  hsr_pkg::cmd_type                     cmd,
   output hsr_pkg::status_type                  status,
   output logic [hsr_pkg::ROOT_W-1:0]           rsp_root,
   output logic [hsr_pkg::ROUNDS_W-1:0]         rsp_rounds_used,
   output logic                                 rsp_converged
);

   localparam int W     = hsr_pkg::WORK_W;
   localparam int NUM_W = W + FRACTION_BITS;
   localparam int CNT_W = $clog2(NUM_W);
   localparam logic [W-1:0] ONE = W'(1) << FRACTION_BITS;
   localparam logic [hsr_pkg::LIMIT_W-1:0] MAX_R = hsr_pkg::LIMIT_W'(MAX_ROUNDS);
   localparam logic [W-1:0] ROOT_MAX = W'(hsr_pkg::ROOT_SAT);

   logic [hsr_pkg::TOL_W-1:0]    tol_ff;
   logic [hsr_pkg::LIMIT_W-1:0]  limit_ff;
   logic [W-1:0]                 a_ff;
   logic                         not_positive_ff;
   logic [W-1:0]                 x_ff, x_in;
   logic [W-1:0]                 y_ff, y_in;
   logic [hsr_pkg::ROUNDS_W-1:0] rounds_ff, rounds_in;
   logic [W-1:0]                 rem_ff, rem_in;
   logic [NUM_W-1:0]             shift_ff, shift_in;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic [hsr_pkg::ROOT_W-1:0]   root_ff;
   logic [hsr_pkg::ROUNDS_W-1:0] rounds_out_ff;
   logic                         converged_ff;

   logic [W-1:0]                 diff;
   logic [W:0]                   sum;
   logic [hsr_pkg::LIMIT_W-1:0]  limit_eff;
   logic [W:0]                   partial;
   logic                         fits;
   logic [W:0]                   reduced;
   logic [NUM_W-1:0]             quot;
   logic [W-1:0]                 quot_sat;
   logic                         load_positive;

   assign diff      = (x_ff >= y_ff) ? (x_ff - y_ff) : (y_ff - x_ff);
   assign sum       = {1'b0, x_ff} + {1'b0, y_ff};
   assign limit_eff = (limit_ff > MAX_R) ? MAX_R : limit_ff;

   // restoring divide step; remainder stays below x, so it fits W bits
   assign partial  = {rem_ff, shift_ff[NUM_W-1]};
   assign fits     = (partial >= {1'b0, x_ff});
   assign reduced  = partial - {1'b0, x_ff};
   assign rem_in   = fits ? reduced[W-1:0] : partial[W-1:0];
   assign quot     = {shift_ff[NUM_W-2:0], fits};
   // a zero divisor yields an all-ones quotient and saturates here too
   assign quot_sat = (quot[NUM_W-1:W] != '0) ? {W{1'b1}} : quot[W-1:0];

   assign load_positive = (req_radicand != '0) && !req_radicand[hsr_pkg::RADICAND_W-1];

   assign status.not_positive = not_positive_ff;
   assign status.within_tol   = (diff <= W'(tol_ff));
   assign status.limit_hit    = (rounds_ff >= limit_eff);
   assign status.div_last     = (count_ff == '0);

   always_comb begin
      x_in      = x_ff;
      y_in      = y_ff;
      rounds_in = rounds_ff;
      shift_in  = shift_ff;
      count_in  = count_ff;
      priority if (cmd.load) begin
         // a non-positive radicand leaves the estimate and quotient alone
         if (load_positive) begin
            x_in = W'(req_radicand);
            y_in = ONE;
         end
         rounds_in = '0;
      end else if (cmd.start_round) begin
         x_in      = sum[W:1];
         rounds_in = rounds_ff + 1'b1;
         shift_in  = {a_ff, {FRACTION_BITS{1'b0}}};
         count_in  = CNT_W'(NUM_W - 1);
      end else if (cmd.div_step) begin
         shift_in = quot;
         count_in = count_ff - 1'b1;
         if (count_ff == '0) begin
            y_in = quot_sat;
         end
      end else begin
         x_in = x_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff   <= hsr_pkg::TOLERANCE_RESET;
         limit_ff <= hsr_pkg::LIMIT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            hsr_pkg::CSR_TOLERANCE_LSBS: begin
               tol_ff <= csr_write_data;
            end
            hsr_pkg::CSR_ITERATION_LIMIT: begin
               limit_ff <= csr_write_data[hsr_pkg::LIMIT_W-1:0];
            end
            default: begin
               tol_ff <= tol_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff <= '0;
         y_ff <= '0;
      end else begin
         x_ff <= x_in;
         y_ff <= y_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         a_ff            <= W'(req_radicand);
         not_positive_ff <= !load_positive;
      end
      if (cmd.start_round) begin
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
      end
      rounds_ff <= rounds_in;
      shift_ff  <= shift_in;
      count_ff  <= count_in;
      if (cmd.capture) begin
         if (not_positive_ff) begin
            root_ff       <= '0;
            rounds_out_ff <= '0;
         end else begin
            root_ff       <= (x_ff > ROOT_MAX) ? hsr_pkg::ROOT_SAT
                                               : x_ff[hsr_pkg::ROOT_W-1:0];
            rounds_out_ff <= rounds_ff;
         end
         converged_ff <= not_positive_ff || status.within_tol;
      end
   end

   assign rsp_root        = root_ff;
   assign rsp_rounds_used = rounds_out_ff;
   assign rsp_converged   = converged_ff;

endmodule

FILE: sv/heron_square_root.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heron_square_root: Q16.16 square root by Heron's iteration
// Sequencer plus datapath with a one-bit-per-cycle restoring divider.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one signed radicand word; it is taken when req_valid is high
//   and req_stall is low. req_stall is low only while the block is idle.
//   rsp_* returns root, rounds_used and converged; the word is taken when
//   rsp_valid is high and rsp_stall is low. A finished word waits in the
//   result register while the next radicand is accepted.
//   csr_write_enable/csr_index/csr_write_data write tolerance_lsbs (index 0)
//   and iteration_limit (index 1); write only while the block is idle.
// Sequence:
//   Each round runs a check state and then D = 32 + FRACTION_BITS divider
//   bits (D is 48 at Q16.16), one quotient bit per cycle; the word then
//   passes to the finish state and the result register. A non-positive
//   radicand goes from the check state straight to the finish state. A word
//   is taken only once the last one has been captured and the block is idle.
// Reset:
//   Synchronous; clears the sequencer and rsp_valid, restores the register
//   defaults (tolerance 1, limit 32) and zeroes the estimate and quotient.
// Stall:
//   A stalled result holds; a word that finishes meanwhile waits in its last
//   state until the result register frees up.
// ----------------------------------------------------------------------------
module heron_square_root #(
   parameter int FRACTION_BITS = 16,
   parameter int MAX_ROUNDS    = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [hsr_pkg::RADICAND_W-1:0] req_radicand,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [hsr_pkg::ROOT_W-1:0]            rsp_root,
   output logic [hsr_pkg::ROUNDS_W-1:0]          rsp_rounds_used,
   output logic                                  rsp_converged,
   input  logic                                  csr_write_enable,
   input  logic [hsr_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [hsr_pkg::CSR_DATA_W-1:0]        csr_write_data
);

   hsr_pkg::cmd_type    cmd;
   hsr_pkg::status_type status;

   // sequencer: checks, rounds and handshake flags
   hsr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // estimate, quotient, divider, settings and result register
   hsr_datapath #(
      .FRACTION_BITS (FRACTION_BITS),
      .MAX_ROUNDS    (MAX_ROUNDS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_radicand     (req_radicand),
      .cmd              (cmd),
      .status           (status),
      .rsp_root         (rsp_root),
      .rsp_rounds_used  (rsp_rounds_used),
      .rsp_converged    (rsp_converged)
   );

endmodule
